/* rtl/tpda_pkg.sv */
// ----------------------------------------------------------------------------
// tpda_pkg
// Shared types and constants for the two-point direction angle block.
// ----------------------------------------------------------------------------
`default_nettype none
package tpda_pkg;

	// internal CORDIC datapath width (differences lie within +-2^57)
	localparam int CW = 62;
	// internal angle width, full turn is 2^32
	localparam int AW = 34;
	// scaled differences sit at this many bits
	localparam int SCALED_BITS = 57;
	localparam int STEP_TABLE_LEN = 24;
	localparam logic [30:0] GAIN_Q30 = 31'd1768195363;
	localparam logic signed [AW-1:0] QUARTER_TURN = AW'(64'sh40000000);
	localparam logic signed [AW-1:0] HALF_TURN = AW'(64'sh80000000);

	localparam logic [31:0] STEP_ANGLE [STEP_TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// classification of one beat
	typedef struct packed {
		logic same;
		logic vert;
		logic dz_neg;
	} tpda_flags_t;

endpackage
`default_nettype wire

/* rtl/two_point_direction_angles.sv */
// ----------------------------------------------------------------------------
// two_point_direction_angles
// Polar angle and azimuth of the line between two 3D points.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | start, busy        | start_x/y/z, end_x/y/z
//  result   | done (one cycle)   | polar_angle, azimuth_angle, same_point
//
//  One pair may be taken every cycle; the back drains the queue every cycle,
//  so the queue holds at most one beat and busy stays low.
//  done rises once the accepted pair has passed the front register, the queue,
//  two gain multiply stages, two CORDIC pipelines of ROTATION_STEPS + 1
//  stages each, and the result register.
//  Reset clears all valid flags; no clearing pass is needed.
//  The receiver cannot stall: each result shows for one cycle with done.
// ----------------------------------------------------------------------------
`default_nettype none
module two_point_direction_angles #(
	parameter int COORD_BITS     = 32,
	parameter int ANGLE_BITS     = 16,
	parameter int ROTATION_STEPS = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] start_z,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	input  wire logic signed [COORD_BITS-1:0] end_z,
	output logic                              done,
	output logic [ANGLE_BITS-1:0]             polar_angle,
	output logic signed [ANGLE_BITS-1:0]      azimuth_angle,
	output logic                              same_point
);
	import tpda_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int QW = 3 * DW + $bits(tpda_flags_t);

	logic accept, vld_s1, q_empty;
	logic signed [DW-1:0] dx_s1, dy_s1, dz_s1;
	tpda_flags_t flags_s1;
	logic [QW-1:0] q_rdata;

	assign accept = start && !busy;

	// front: differences and classification
	tpda_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.start_x  (start_x),
		.start_y  (start_y),
		.start_z  (start_z),
		.end_x    (end_x),
		.end_y    (end_y),
		.end_z    (end_z),
		.vld_s1   (vld_s1),
		.dx_s1    (dx_s1),
		.dy_s1    (dy_s1),
		.dz_s1    (dz_s1),
		.flags_s1 (flags_s1)
	);

	// queue between front and back
	tpda_queue #(.WIDTH(QW)) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (vld_s1),
		.wdata       ({dx_s1, dy_s1, dz_s1, flags_s1}),
		.pop         (1'b1),
		.rdata       (q_rdata),
		.empty       (q_empty),
		.almost_full (busy)
	);

	// back: gain and both CORDICs
	tpda_back #(
		.COORD_BITS     (COORD_BITS),
		.ANGLE_BITS     (ANGLE_BITS),
		.ROTATION_STEPS (ROTATION_STEPS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.vld_in        (!q_empty),
		.dx_in         ($signed(q_rdata[QW-1 -: DW])),
		.dy_in         ($signed(q_rdata[QW-1-DW -: DW])),
		.dz_in         ($signed(q_rdata[QW-1-2*DW -: DW])),
		.flags_in      (tpda_flags_t'(q_rdata[$bits(tpda_flags_t)-1:0])),
		.done          (done),
		.polar_angle   (polar_angle),
		.azimuth_angle (azimuth_angle),
		.same_point    (same_point)
	);
endmodule
`default_nettype wire

/* rtl/tpda_queue.sv */
// ----------------------------------------------------------------------------
// tpda_queue
// Small FIFO between front and back; flags almost full to hold off start.
// ----------------------------------------------------------------------------
`default_nettype none
module tpda_queue #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty,
	output logic                  almost_full
);
	localparam int DEPTH = 4;
	localparam int PW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0] count_q;
	logic do_pop;

	assign empty = (count_q == '0);
	// one slot kept for the beat held in the front register
	assign almost_full = (count_q >= (PW+1)'(DEPTH - 1));
	assign do_pop = pop && !empty;
	assign rdata = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !do_pop) count_q <= count_q + 1'b1;
			else if (!push && do_pop) count_q <= count_q - 1'b1;
		end
	end
endmodule
`default_nettype wire

/* rtl/tpda_front.sv */
// ----------------------------------------------------------------------------
// tpda_front
// Takes a point pair, forms the differences and classifies the beat.
// ----------------------------------------------------------------------------
`default_nettype none
module tpda_front #(
	parameter int COORD_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] start_z,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	input  wire logic signed [COORD_BITS-1:0] end_z,
	output logic                              vld_s1,
	output logic signed [COORD_BITS:0]        dx_s1,
	output logic signed [COORD_BITS:0]        dy_s1,
	output logic signed [COORD_BITS:0]        dz_s1,
	output tpda_pkg::tpda_flags_t             flags_s1
);
	import tpda_pkg::*;

	logic signed [COORD_BITS:0] dx, dy, dz;
	tpda_flags_t flags;

	// exact differences
	assign dx = $signed({end_x[COORD_BITS-1], end_x}) - $signed({start_x[COORD_BITS-1], start_x});
	assign dy = $signed({end_y[COORD_BITS-1], end_y}) - $signed({start_y[COORD_BITS-1], start_y});
	assign dz = $signed({end_z[COORD_BITS-1], end_z}) - $signed({start_z[COORD_BITS-1], start_z});

	// classify
	always_comb begin
		flags.vert   = (dx == '0) && (dy == '0);
		flags.same   = flags.vert && (dz == '0);
		flags.dz_neg = dz[COORD_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dx_s1    <= dx;
			dy_s1    <= dy;
			dz_s1    <= dz;
			flags_s1 <= flags;
		end
	end
endmodule
`default_nettype wire

/* rtl/tpda_cordic.sv */
// ----------------------------------------------------------------------------
// tpda_cordic
// Pipelined vectoring CORDIC, one micro-rotation per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none
module tpda_cordic #(
	parameter int STEPS = 16,
	parameter int SB_W  = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           vld_in,
	input  wire logic signed [tpda_pkg::CW-1:0] x_in,
	input  wire logic signed [tpda_pkg::CW-1:0] y_in,
	input  wire logic [SB_W-1:0]                sb_in,
	output logic                                vld_out,
	output logic signed [tpda_pkg::CW-1:0]      mag_out,
	output logic signed [tpda_pkg::AW-1:0]      ang_out,
	output logic [SB_W-1:0]                     sb_out
);
	import tpda_pkg::*;

	logic                 vld_s [STEPS+1];
	logic signed [CW-1:0] x_s   [STEPS+1];
	logic signed [CW-1:0] y_s   [STEPS+1];
	logic signed [AW-1:0] ang_s [STEPS+1];
	logic [SB_W-1:0]      sb_s  [STEPS+1];

	// quadrant pre-rotation for x < 0
	always_ff @(posedge clk) begin
		sb_s[0] <= sb_in;
		if (x_in[CW-1]) begin
			if (!y_in[CW-1]) begin
				x_s[0]   <= y_in;
				y_s[0]   <= -x_in;
				ang_s[0] <= QUARTER_TURN;
			end else begin
				x_s[0]   <= -y_in;
				y_s[0]   <= x_in;
				ang_s[0] <= -QUARTER_TURN;
			end
		end else begin
			x_s[0]   <= x_in;
			y_s[0]   <= y_in;
			ang_s[0] <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s[0] <= 1'b0;
		else         vld_s[0] <= vld_in;
	end

	// micro-rotation stages
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [AW-1:0] STEP_ANG =
			$signed({{(AW-32){1'b0}}, STEP_ANGLE[i]});

		always_ff @(posedge clk) begin
			sb_s[i+1] <= sb_s[i];
			if (!y_s[i][CW-1]) begin
				x_s[i+1]   <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1]   <= y_s[i] - (x_s[i] >>> i);
				ang_s[i+1] <= ang_s[i] + STEP_ANG;
			end else begin
				x_s[i+1]   <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1]   <= y_s[i] + (x_s[i] >>> i);
				ang_s[i+1] <= ang_s[i] - STEP_ANG;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i+1] <= 1'b0;
			else         vld_s[i+1] <= vld_s[i];
		end
	end

	assign vld_out = vld_s[STEPS];
	assign mag_out = x_s[STEPS];
	assign ang_out = ang_s[STEPS];
	assign sb_out  = sb_s[STEPS];
endmodule
`default_nettype wire

/* rtl/tpda_back.sv */
// ----------------------------------------------------------------------------
// tpda_back
// Scales the differences, applies the gain to dz and runs both CORDICs.
// ----------------------------------------------------------------------------
`default_nettype none
module tpda_back #(
	parameter int COORD_BITS     = 32,
	parameter int ANGLE_BITS     = 16,
	parameter int ROTATION_STEPS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        vld_in,
	input  wire logic signed [COORD_BITS:0]  dx_in,
	input  wire logic signed [COORD_BITS:0]  dy_in,
	input  wire logic signed [COORD_BITS:0]  dz_in,
	input  wire tpda_pkg::tpda_flags_t       flags_in,
	output logic                             done,
	output logic [ANGLE_BITS-1:0]            polar_angle,
	output logic signed [ANGLE_BITS-1:0]     azimuth_angle,
	output logic                             same_point
);
	import tpda_pkg::*;

	localparam int DW = COORD_BITS + 1;
	localparam int GUARD = SCALED_BITS - COORD_BITS;
	localparam int FW = $bits(tpda_flags_t);
	localparam logic [31:0] HALF = 32'(1) << (31 - ANGLE_BITS);

	logic signed [CW-1:0] dx_sc, dy_sc, dz_sc;
	logic [SCALED_BITS:0] mag;
	logic [27:0] hi;
	logic [29:0] lo;

	logic                 vld_g1, vld_g2;
	logic signed [CW-1:0] dx_g1, dy_g1, dx_g2, dy_g2, gdz_g2;
	logic                 neg_g1;
	logic [58:0]          phi_g1;
	logic [60:0]          plo_g1;
	tpda_flags_t          flags_g1, flags_g2;
	logic [59:0]          r;

	// scale by the guard bits
	assign dx_sc = $signed({{(CW-DW){dx_in[DW-1]}}, dx_in}) <<< GUARD;
	assign dy_sc = $signed({{(CW-DW){dy_in[DW-1]}}, dy_in}) <<< GUARD;
	assign dz_sc = $signed({{(CW-DW){dz_in[DW-1]}}, dz_in}) <<< GUARD;

	// magnitude split for the gain multiply
	always_comb begin
		logic signed [CW-1:0] a;
		a   = dz_sc[CW-1] ? -dz_sc : dz_sc;
		mag = a[SCALED_BITS:0];
		hi  = mag[57:30];
		lo  = mag[29:0];
	end

	// gain stage one: partial products
	always_ff @(posedge clk) begin
		dx_g1    <= dx_sc;
		dy_g1    <= dy_sc;
		neg_g1   <= dz_sc[CW-1];
		flags_g1 <= flags_in;
		phi_g1   <= 59'(hi) * 59'(GAIN_Q30);
		plo_g1   <= 61'(lo) * 61'(GAIN_Q30);
	end

	// gain stage two: sum with round half up, then sign
	assign r = 60'(phi_g1) + 60'((plo_g1 + 61'(1) * (61'(1) << 29)) >> 30);

	always_ff @(posedge clk) begin
		dx_g2    <= dx_g1;
		dy_g2    <= dy_g1;
		flags_g2 <= flags_g1;
		gdz_g2   <= neg_g1 ? -$signed(CW'(r)) : $signed(CW'(r));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_g1 <= 1'b0;
			vld_g2 <= 1'b0;
		end else begin
			vld_g1 <= vld_in;
			vld_g2 <= vld_g1;
		end
	end

	// azimuth CORDIC, also gives rho
	logic                 vld_c1;
	logic signed [CW-1:0] rho_c1;
	logic signed [AW-1:0] az_c1;
	logic [CW+FW-1:0]     sb_c1;

	tpda_cordic #(.STEPS(ROTATION_STEPS), .SB_W(CW+FW)) u_cordic_az (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_g2),
		.x_in    (dx_g2),
		.y_in    (dy_g2),
		.sb_in   ({gdz_g2, flags_g2}),
		.vld_out (vld_c1),
		.mag_out (rho_c1),
		.ang_out (az_c1),
		.sb_out  (sb_c1)
	);

	// polar CORDIC on (gained dz, rho)
	logic                 vld_c2;
	logic signed [CW-1:0] unused_mag;
	logic signed [AW-1:0] pol_c2;
	logic [AW+FW-1:0]     sb_c2;
	tpda_flags_t          flags_c2;
	logic signed [AW-1:0] az_c2;

	tpda_cordic #(.STEPS(ROTATION_STEPS), .SB_W(AW+FW)) u_cordic_pol (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_c1),
		.x_in    ($signed(sb_c1[CW+FW-1:FW])),
		.y_in    (rho_c1),
		.sb_in   ({az_c1, sb_c1[FW-1:0]}),
		.vld_out (vld_c2),
		.mag_out (unused_mag),
		.ang_out (pol_c2),
		.sb_out  (sb_c2)
	);

	assign flags_c2 = sb_c2[FW-1:0];
	assign az_c2    = $signed(sb_c2[AW+FW-1:FW]);

	// clamp, special cases and rounding to output units
	logic signed [AW-1:0] pol_fix, az_fix;
	logic [31:0] pol_r, az_r;

	always_comb begin
		if (flags_c2.vert) begin
			pol_fix = flags_c2.dz_neg ? HALF_TURN : '0;
			az_fix  = '0;
		end else begin
			if (pol_c2[AW-1])            pol_fix = '0;
			else if (pol_c2 > HALF_TURN) pol_fix = HALF_TURN;
			else                         pol_fix = pol_c2;
			az_fix = az_c2;
		end
		pol_r = pol_fix[31:0] + HALF;
		az_r  = az_fix[31:0] + HALF;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= vld_c2;
	end

	// result register
	always_ff @(posedge clk) begin
		if (vld_c2) begin
			same_point <= flags_c2.same;
			if (flags_c2.same) begin
				polar_angle   <= '0;
				azimuth_angle <= '0;
			end else begin
				polar_angle   <= pol_r[31:32-ANGLE_BITS];
				azimuth_angle <= $signed(az_r[31:32-ANGLE_BITS]);
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/tpda_checker.sv */
// ----------------------------------------------------------------------------
// tpda_checker
// Port-level checks on the result channel of the direction angle block.
// ----------------------------------------------------------------------------
`default_nettype none
module tpda_checker #(
	parameter int ANGLE_BITS = 16
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  done,
	input wire logic [ANGLE_BITS-1:0] polar_angle,
	input wire logic [ANGLE_BITS-1:0] azimuth_angle,
	input wire logic                  same_point
);
	localparam logic [ANGLE_BITS-1:0] PI_CODE = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

	// coinciding points give zero angles
	a_same_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && same_point |-> polar_angle == '0 && azimuth_angle == '0)
		else $error("same_point with nonzero angles");

	// polar angle never beyond pi
	a_polar_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> polar_angle <= PI_CODE)
		else $error("polar angle above pi");

	// no result strobe while in reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !done)
		else $error("done during reset");
endmodule

bind two_point_direction_angles tpda_checker #(.ANGLE_BITS(ANGLE_BITS)) u_tpda_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.done          (done),
	.polar_angle   (polar_angle),
	.azimuth_angle (azimuth_angle),
	.same_point    (same_point)
);
`default_nettype wire
